FILE: design/pfvn_pkg.sv
// Shared types and datapath command codes for the polygon fan vertex normal block.
package pfvn_pkg;

  localparam int POS_W = 24;
  localparam int NRM_W = 16;
  localparam int IDX_W = 5;
  localparam int ACC_W = 64;
  localparam int CRS_W = 51;
  localparam int NUM_W = 45;
  localparam int STEP_W = 6;

  localparam logic [4:0] OP_NONE = 5'd0;
  localparam logic [4:0] OP_LOAD = 5'd1;
  localparam logic [4:0] OP_CLR  = 5'd2;
  localparam logic [4:0] OP_CAPB = 5'd3;
  localparam logic [4:0] OP_EDGE = 5'd4;
  localparam logic [4:0] OP_MUL  = 5'd5;
  localparam logic [4:0] OP_AWR  = 5'd6;
  localparam logic [4:0] OP_MAG  = 5'd7;
  localparam logic [4:0] OP_SHF  = 5'd8;
  localparam logic [4:0] OP_SQ   = 5'd9;
  localparam logic [4:0] OP_SQI  = 5'd10;
  localparam logic [4:0] OP_SQT  = 5'd11;
  localparam logic [4:0] OP_DVI  = 5'd12;
  localparam logic [4:0] OP_DIV  = 5'd13;
  localparam logic [4:0] OP_DVE  = 5'd14;

  typedef struct packed {
    logic [4:0]        op;
    logic [STEP_W-1:0] step;
    logic [1:0]        comp;
  } pfvn_cmd_t;

  typedef struct packed {
    logic big;
  } pfvn_stat_t;

endpackage

FILE: design/pfvn_ctrl.sv
// Controller state machine: vertex loading, triangle walk, normalize sequencing, output.
module pfvn_ctrl import pfvn_pkg::*; #(
  parameter int MAX_VERTS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [IDX_W-1:0]              out_vertex_index,
  output logic                          out_overflowed,
  output logic                          out_last_normal,
  output pfvn_cmd_t                     cmd,
  output logic [$clog2(MAX_VERTS)-1:0]  st_addr,
  output logic [$clog2(MAX_VERTS)-1:0]  acc_addr,
  input  pfvn_stat_t                    stat
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_TB   = 4'd2;
  localparam logic [3:0] S_TC   = 4'd3;
  localparam logic [3:0] S_TE   = 4'd4;
  localparam logic [3:0] S_TM   = 4'd5;
  localparam logic [3:0] S_TAR  = 4'd6;
  localparam logic [3:0] S_TAW  = 4'd7;
  localparam logic [3:0] S_NRD  = 4'd8;
  localparam logic [3:0] S_NMG  = 4'd9;
  localparam logic [3:0] S_NSH  = 4'd10;
  localparam logic [3:0] S_NSQ  = 4'd11;
  localparam logic [3:0] S_NSI  = 4'd12;
  localparam logic [3:0] S_NSQT = 4'd13;
  localparam logic [3:0] S_NDI  = 4'd14;
  localparam logic [3:0] S_NDV  = 4'd15;

  logic [3:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     t_r, t_nxt;
  logic [1:0]        j_r, j_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              ovf_r, ovf_nxt;
  logic              outv_r, outv_nxt;
  logic              in_acc, out_acc, room, idx_last;
  logic [CW-1:0]     tb, tc, vsel;

  assign room     = cnt_r < CW'(MAX_VERTS);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = outv_r && !out_stall;
  assign idx_last = idx_r == n_r - CW'(1);
  assign tb       = t_r + CW'(1);
  assign tc       = t_r + CW'(2);

  always_comb begin
    case (j_r)
      2'd0:    vsel = '0;
      2'd1:    vsel = tb;
      default: vsel = tc;
    endcase
  end

  assign in_stall         = state_r != S_IDLE;
  assign out_valid        = outv_r;
  assign out_vertex_index = IDX_W'(idx_r);
  assign out_overflowed   = ovf_r;
  assign out_last_normal  = idx_last;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    t_nxt     = t_r;
    j_nxt     = j_r;
    comp_nxt  = comp_r;
    step_nxt  = step_r;
    ovf_nxt   = ovf_r;
    outv_nxt  = outv_r;
    cmd.op    = OP_NONE;
    cmd.step  = step_r;
    cmd.comp  = comp_r;
    st_addr   = cnt_r[AW-1:0];
    acc_addr  = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (room) begin
            cmd.op  = OP_LOAD;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_vertex) begin
            n_nxt     = room ? cnt_r + CW'(1) : cnt_r;
            idx_nxt   = '0;
            state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (idx_last) begin
          idx_nxt = '0;
          t_nxt   = '0;
          state_nxt = (n_r >= CW'(3)) ? S_TB : S_NRD;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_TB: begin
        st_addr   = tb[AW-1:0];
        state_nxt = S_TC;
      end
      S_TC: begin
        st_addr   = tc[AW-1:0];
        cmd.op    = OP_CAPB;
        state_nxt = S_TE;
      end
      S_TE: begin
        cmd.op    = OP_EDGE;
        step_nxt  = '0;
        state_nxt = S_TM;
      end
      S_TM: begin
        cmd.op = OP_MUL;
        if (step_r == STEP_W'(6)) begin
          j_nxt     = '0;
          state_nxt = S_TAR;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_TAR: begin
        acc_addr  = vsel[AW-1:0];
        state_nxt = S_TAW;
      end
      S_TAW: begin
        acc_addr = vsel[AW-1:0];
        cmd.op   = OP_AWR;
        if (j_r == 2'd2) begin
          if ((CW + 1)'(t_r) + (CW + 1)'(3) < (CW + 1)'(n_r)) begin
            t_nxt     = tb;
            state_nxt = S_TB;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_NRD;
          end
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_TAR;
        end
      end
      S_NRD: begin
        if (outv_r) begin
          if (out_acc) begin
            outv_nxt = 1'b0;
            if (idx_last) begin
              cnt_nxt   = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
        end else begin
          state_nxt = S_NMG;
        end
      end
      S_NMG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_NSH;
      end
      S_NSH: begin
        if (stat.big) begin
          cmd.op = OP_SHF;
        end else begin
          step_nxt  = '0;
          state_nxt = S_NSQ;
        end
      end
      S_NSQ: begin
        cmd.op = OP_SQ;
        if (step_r == STEP_W'(3)) begin
          state_nxt = S_NSI;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_NSI: begin
        cmd.op    = OP_SQI;
        step_nxt  = '0;
        state_nxt = S_NSQT;
      end
      S_NSQT: begin
        cmd.op = OP_SQT;
        if (step_r == STEP_W'(31)) begin
          comp_nxt  = '0;
          state_nxt = S_NDI;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_NDI: begin
        cmd.op    = OP_DVI;
        step_nxt  = '0;
        state_nxt = S_NDV;
      end
      S_NDV: begin
        if (step_r == STEP_W'(NUM_W)) begin
          // Quotient is complete: store this component.
          cmd.op = OP_DVE;
          if (comp_r == 2'd2) begin
            outv_nxt  = 1'b1;
            state_nxt = S_NRD;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = S_NDI;
          end
        end else begin
          cmd.op   = OP_DIV;
          step_nxt = step_r + STEP_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
      idx_r   <= '0;
      t_r     <= '0;
      j_r     <= '0;
      comp_r  <= '0;
      step_r  <= '0;
      ovf_r   <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
      t_r     <= t_nxt;
      j_r     <= j_nxt;
      comp_r  <= comp_nxt;
      step_r  <= step_nxt;
      ovf_r   <= ovf_nxt;
      outv_r  <= outv_nxt;
    end
  end

endmodule

FILE: design/pfvn_dp.sv
// Datapath: vertex and accumulator memories, shared multiplier, square root and divider.
module pfvn_dp import pfvn_pkg::*; #(
  parameter int MAX_VERTS = 32
) (
  input  logic                          clk,
  input  logic signed [POS_W-1:0]       in_pos_x,
  input  logic signed [POS_W-1:0]       in_pos_y,
  input  logic signed [POS_W-1:0]       in_pos_z,
  input  pfvn_cmd_t                     cmd,
  input  logic [$clog2(MAX_VERTS)-1:0]  st_addr,
  input  logic [$clog2(MAX_VERTS)-1:0]  acc_addr,
  output pfvn_stat_t                    stat,
  output logic signed [NRM_W-1:0]       out_norm_x,
  output logic signed [NRM_W-1:0]       out_norm_y,
  output logic signed [NRM_W-1:0]       out_norm_z
);

  logic [3*POS_W-1:0] st_mem [MAX_VERTS];
  logic [3*ACC_W-1:0] acc_mem [MAX_VERTS];
  logic [3*POS_W-1:0] st_rd_r, p0_r, pb_r;
  logic [3*ACC_W-1:0] acc_rd_r;

  logic signed [POS_W:0]   e1_r [3];
  logic signed [POS_W:0]   e2_r [3];
  logic signed [CRS_W-1:0] n_r [3];
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      prod_r;
  logic [ACC_W-1:0]        m_r [3];
  logic [2:0]              neg_r;
  logic [63:0]             sum_r, v_r, r_r, bit_r, trial;
  logic [NUM_W-1:0]        num_r;
  logic [31:0]             rem_r, len;
  logic [32:0]             rtmp;
  logic signed [NRM_W-1:0] nrm_r [3];
  logic [14:0]             qmag;
  logic [NRM_W-1:0]        qval;
  logic [2:0]              k;

  assign len      = r_r[31:0];
  assign trial    = r_r + bit_r;
  assign rtmp     = {rem_r, num_r[NUM_W-1]};
  assign stat.big = |m_r[0][ACC_W-1:30] || |m_r[1][ACC_W-1:30] || |m_r[2][ACC_W-1:30];
  assign k        = cmd.step[2:0] - 3'd1;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      st_mem[st_addr] <= {in_pos_x, in_pos_y, in_pos_z};
      if (st_addr == '0) begin
        p0_r <= {in_pos_x, in_pos_y, in_pos_z};
      end
    end
    st_rd_r <= st_mem[st_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLR) begin
      acc_mem[acc_addr] <= '0;
    end else if (cmd.op == OP_AWR) begin
      acc_mem[acc_addr] <= {
        acc_rd_r[3*ACC_W-1:2*ACC_W] - ACC_W'(n_r[0]),
        acc_rd_r[2*ACC_W-1:ACC_W]   - ACC_W'(n_r[1]),
        acc_rd_r[ACC_W-1:0]         - ACC_W'(n_r[2])};
    end
    acc_rd_r <= acc_mem[acc_addr];
  end

  // Operand select: cross-product terms, or squared magnitudes.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == OP_MUL) begin
      case (cmd.step[2:0])
        3'd0: begin mul_a = 32'(e1_r[1]); mul_b = 32'(e2_r[2]); end
        3'd1: begin mul_a = 32'(e1_r[2]); mul_b = 32'(e2_r[1]); end
        3'd2: begin mul_a = 32'(e1_r[2]); mul_b = 32'(e2_r[0]); end
        3'd3: begin mul_a = 32'(e1_r[0]); mul_b = 32'(e2_r[2]); end
        3'd4: begin mul_a = 32'(e1_r[0]); mul_b = 32'(e2_r[1]); end
        3'd5: begin mul_a = 32'(e1_r[1]); mul_b = 32'(e2_r[0]); end
        default: ;
      endcase
    end else begin
      case (cmd.step[1:0])
        2'd0:    begin mul_a = {2'b0, m_r[0][29:0]}; mul_b = {2'b0, m_r[0][29:0]}; end
        2'd1:    begin mul_a = {2'b0, m_r[1][29:0]}; mul_b = {2'b0, m_r[1][29:0]}; end
        default: begin mul_a = {2'b0, m_r[2][29:0]}; mul_b = {2'b0, m_r[2][29:0]}; end
      endcase
    end
  end

  always_comb begin
    qmag = (num_r > NUM_W'(16384)) ? 15'd16384 : num_r[14:0];
    qval = (len == '0) ? '0 : NRM_W'(qmag);
    if (neg_r[cmd.comp]) begin
      qval = -qval;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_CAPB: pb_r <= st_rd_r;
      OP_EDGE: begin
        e1_r[0] <= (POS_W + 1)'($signed(p0_r[3*POS_W-1:2*POS_W]))
                 - (POS_W + 1)'($signed(pb_r[3*POS_W-1:2*POS_W]));
        e1_r[1] <= (POS_W + 1)'($signed(p0_r[2*POS_W-1:POS_W]))
                 - (POS_W + 1)'($signed(pb_r[2*POS_W-1:POS_W]));
        e1_r[2] <= (POS_W + 1)'($signed(p0_r[POS_W-1:0]))
                 - (POS_W + 1)'($signed(pb_r[POS_W-1:0]));
        e2_r[0] <= (POS_W + 1)'($signed(st_rd_r[3*POS_W-1:2*POS_W]))
                 - (POS_W + 1)'($signed(pb_r[3*POS_W-1:2*POS_W]));
        e2_r[1] <= (POS_W + 1)'($signed(st_rd_r[2*POS_W-1:POS_W]))
                 - (POS_W + 1)'($signed(pb_r[2*POS_W-1:POS_W]));
        e2_r[2] <= (POS_W + 1)'($signed(st_rd_r[POS_W-1:0]))
                 - (POS_W + 1)'($signed(pb_r[POS_W-1:0]));
      end
      OP_MUL: begin
        // The product of the previous step lands here; even terms load the component, odd ones subtract.
        if (cmd.step != '0) begin
          if (k[0]) begin
            n_r[k[2:1]] <= n_r[k[2:1]] - CRS_W'(prod_r);
          end else begin
            n_r[k[2:1]] <= CRS_W'(prod_r);
          end
        end
      end
      OP_MAG: begin
        m_r[0] <= acc_rd_r[3*ACC_W-1] ? -acc_rd_r[3*ACC_W-1:2*ACC_W]
                                      : acc_rd_r[3*ACC_W-1:2*ACC_W];
        m_r[1] <= acc_rd_r[2*ACC_W-1] ? -acc_rd_r[2*ACC_W-1:ACC_W]
                                      : acc_rd_r[2*ACC_W-1:ACC_W];
        m_r[2] <= acc_rd_r[ACC_W-1] ? -acc_rd_r[ACC_W-1:0] : acc_rd_r[ACC_W-1:0];
        neg_r  <= {acc_rd_r[ACC_W-1], acc_rd_r[2*ACC_W-1], acc_rd_r[3*ACC_W-1]};
      end
      OP_SHF: begin
        m_r[0] <= m_r[0] >> 1;
        m_r[1] <= m_r[1] >> 1;
        m_r[2] <= m_r[2] >> 1;
      end
      OP_SQ: begin
        if (cmd.step == '0) begin
          sum_r <= '0;
        end else begin
          sum_r <= sum_r + 64'(prod_r);
        end
      end
      OP_SQI: begin
        v_r   <= sum_r;
        r_r   <= '0;
        bit_r <= 64'd1 << 62;
      end
      OP_SQT: begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DVI: begin
        num_r <= {m_r[cmd.comp][29:0], 14'b0} + NUM_W'(len >> 1);
        rem_r <= '0;
      end
      OP_DIV: begin
        if (rtmp >= {1'b0, len}) begin
          rem_r <= 32'(rtmp - {1'b0, len});
          num_r <= {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rtmp[31:0];
          num_r <= {num_r[NUM_W-2:0], 1'b0};
        end
      end
      OP_DVE: nrm_r[cmd.comp] <= qval;
      default: ;
    endcase
  end

  assign out_norm_x = nrm_r[0];
  assign out_norm_y = nrm_r[1];
  assign out_norm_z = nrm_r[2];

endmodule

FILE: design/polygon_fan_vertex_normals.sv
// Top level of the polygon fan vertex normal block: controller plus datapath.
//
//   channel | dir | ports
//   --------+-----+-----------------------------------------------------------
//   in      | in  | in_valid, in_stall, in_pos_x/y/z, in_last_vertex
//   out     | out | out_valid, out_stall, out_vertex_index, out_norm_x/y/z,
//           |     | out_overflowed, out_last_normal
//
// A vertex word that is not marked last is stored at once and the next can follow without a stall.
// The last word starts the computation: the accumulators are cleared, each fan triangle makes
// two vertex reads, the edges, six products on one multiplier and three read-modify-writes,
// and each vertex takes its magnitudes, right shifts until each fits in 30 bits, the sum of
// squares on the shared multiplier, a bit-pair square root and the one-bit-per-cycle divider.
// in_stall stays high from the last word until the final normal word has been taken; out_stall
// holds the current normal word. Reset is synchronous and clears all control state.
module polygon_fan_vertex_normals import pfvn_pkg::*; #(
  parameter int MAX_VERTS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic                    in_last_vertex,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_vertex_index,
  output logic signed [NRM_W-1:0] out_norm_x,
  output logic signed [NRM_W-1:0] out_norm_y,
  output logic signed [NRM_W-1:0] out_norm_z,
  output logic                    out_overflowed,
  output logic                    out_last_normal
);

  localparam int AW = $clog2(MAX_VERTS);

  pfvn_cmd_t     cmd;
  pfvn_stat_t    stat;
  logic [AW-1:0] st_addr;
  logic [AW-1:0] acc_addr;

  // The controller owns the counts, the overflow flag and the output handshake.
  pfvn_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_last_vertex   (in_last_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_index (out_vertex_index),
    .out_overflowed   (out_overflowed),
    .out_last_normal  (out_last_normal),
    .cmd              (cmd),
    .st_addr          (st_addr),
    .acc_addr         (acc_addr),
    .stat             (stat)
  );

  // The datapath holds the vertex and accumulator memories and all arithmetic.
  pfvn_dp #(.MAX_VERTS(MAX_VERTS)) u_dp (
    .clk        (clk),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .cmd        (cmd),
    .st_addr    (st_addr),
    .acc_addr   (acc_addr),
    .stat       (stat),
    .out_norm_x (out_norm_x),
    .out_norm_y (out_norm_y),
    .out_norm_z (out_norm_z)
  );

endmodule

FILE: bench/polygon_fan_vertex_normals_test.sv
// Self-checking bench for the polygon fan vertex normal block: random polygons, predicted normals.
`timescale 1ns / 1ps
module polygon_fan_vertex_normals_test;
  import pfvn_pkg::*;

  localparam int NVERT = 32;

  // One vertex word as sent on the input channel.
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic                    last;
  } vertex_word_t;

  // One normal word as expected on the result channel.
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    ovf;
    logic                    lastn;
  } normal_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [POS_W-1:0] in_pos_z = '0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_vertex_index;
  logic signed [NRM_W-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic out_overflowed, out_last_normal;

  polygon_fan_vertex_normals #(.MAX_VERTS(NVERT)) dut (.*);

  // Predictor state: the stored polygon and its overflow status.
  logic signed [POS_W-1:0] poly_x[NVERT], poly_y[NVERT], poly_z[NVERT];
  int unsigned poly_count = 0;
  bit poly_overflow = 0;

  vertex_word_t pending_words[$];
  normal_word_t expected_normals[$];
  int idle_pct = 0, stall_pct = 0;
  int mismatches = 0, normals_seen = 0, words_sent = 0, polygons_done = 0;
  bit feed_done = 0;

  // Floor square root of a 64-bit value, one result bit at a time.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Turn one accumulated sum into a rounded, clamped Q1.14 unit vector.
  function automatic void unit_normal(input logic signed [63:0] a[3],
                                      output logic signed [NRM_W-1:0] o[3]);
    logic [63:0] m[3];
    logic [63:0] big, len, sumsq, q;
    int sh;
    sumsq = 0;
    for (int k = 0; k < 3; k++) m[k] = a[k] < 0 ? 64'd0 - a[k] : a[k];
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    sh = 0;
    while ((big >> sh) >= (64'd1 << 30)) sh++;
    for (int k = 0; k < 3; k++) begin
      m[k] = m[k] >> sh;
      sumsq += m[k] * m[k];
    end
    len = floor_sqrt(sumsq);
    for (int k = 0; k < 3; k++) begin
      q = 0;
      if (len != 0) begin
        q = (m[k] * 64'd16384 + len / 2) / len;
        if (q > 64'd16384) q = 64'd16384;
      end
      if (a[k] < 0) q = 64'd0 - q;
      o[k] = q[NRM_W-1:0];
    end
  endfunction

  // Accept one vertex word into the predictor; a last word produces the polygon's normals.
  task automatic predict_polygon(input vertex_word_t w);
    logic signed [63:0] acc_x[NVERT], acc_y[NVERT], acc_z[NVERT];
    logic signed [63:0] e1[3], e2[3], cr[3], a[3];
    logic signed [NRM_W-1:0] o[3];
    normal_word_t r;
    int b, c;
    if (poly_count < NVERT) begin
      poly_x[poly_count] = w.px;
      poly_y[poly_count] = w.py;
      poly_z[poly_count] = w.pz;
      poly_count++;
    end else begin
      poly_overflow = 1;
    end
    if (!w.last) return;
    for (int i = 0; i < NVERT; i++) begin
      acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
    end
    for (int i = 0; i + 2 < poly_count; i++) begin
      b = i + 1;
      c = i + 2;
      e1[0] = 64'(poly_x[0]) - 64'(poly_x[b]);
      e1[1] = 64'(poly_y[0]) - 64'(poly_y[b]);
      e1[2] = 64'(poly_z[0]) - 64'(poly_z[b]);
      e2[0] = 64'(poly_x[c]) - 64'(poly_x[b]);
      e2[1] = 64'(poly_y[c]) - 64'(poly_y[b]);
      e2[2] = 64'(poly_z[c]) - 64'(poly_z[b]);
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      acc_x[0] -= cr[0]; acc_y[0] -= cr[1]; acc_z[0] -= cr[2];
      acc_x[b] -= cr[0]; acc_y[b] -= cr[1]; acc_z[b] -= cr[2];
      acc_x[c] -= cr[0]; acc_y[c] -= cr[1]; acc_z[c] -= cr[2];
    end
    for (int i = 0; i < poly_count; i++) begin
      a[0] = acc_x[i]; a[1] = acc_y[i]; a[2] = acc_z[i];
      unit_normal(a, o);
      r.idx = i[IDX_W-1:0];
      r.nx = o[0]; r.ny = o[1]; r.nz = o[2];
      r.ovf = poly_overflow;
      r.lastn = (i + 1 == poly_count);
      expected_normals = {expected_normals, r};
    end
    poly_count = 0;
    poly_overflow = 0;
    polygons_done++;
  endtask

  function automatic logic signed [POS_W-1:0] rand_coord(int mode);
    case (mode)
      0: return POS_W'($urandom());
      1: return POS_W'(int'($urandom_range(8191)) - 4096);
      default: return POS_W'(int'($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  // Queue one polygon of n vertices; mode picks wide, tiny or medium coordinates.
  task automatic queue_polygon(int n, int mode);
    vertex_word_t w;
    for (int i = 0; i < n; i++) begin
      w.px = rand_coord(mode);
      w.py = rand_coord(mode);
      w.pz = rand_coord(mode);
      w.last = (i == n - 1);
      pending_words = {pending_words, w};
    end
  endtask

  task automatic queue_fixed(logic signed [POS_W-1:0] x, y, z, logic last);
    vertex_word_t w;
    w.px = x; w.py = y; w.pz = z; w.last = last;
    pending_words = {pending_words, w};
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // Driver: presents pending words, holds a word while stalled, idles at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_polygon({in_pos_x, in_pos_y, in_pos_z, in_last_vertex});
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          vertex_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_pos_x <= w.px;
          in_pos_y <= w.py;
          in_pos_z <= w.pz;
          in_last_vertex <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted normal word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        normal_word_t got, exp_w;
        got = {out_vertex_index, out_norm_x, out_norm_y, out_norm_z,
               out_overflowed, out_last_normal};
        normals_seen++;
        if (expected_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected normal word %h", got);
        end else begin
          exp_w = expected_normals.pop_front();
          if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("normal mismatch: expected idx %0d n=(%0d,%0d,%0d) ovf %b last %b",
                       exp_w.idx, exp_w.nx, exp_w.ny, exp_w.nz, exp_w.ovf, exp_w.lastn);
              $display("                 got      idx %0d n=(%0d,%0d,%0d) ovf %b last %b",
                       got.idx, got.nx, got.ny, got.nz, got.ovf, got.lastn);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Stimulus and phase control.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: extremes, degenerate polygons, zero area, overflow.
    queue_fixed(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0);
    queue_fixed(24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0);
    queue_fixed(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1'b1);
    queue_fixed(24'sh000100, 24'sh000200, 24'sh000300, 1'b1);
    queue_fixed(24'sh000000, 24'sh000000, 24'sh000000, 1'b0);
    queue_fixed(24'shFFFFFF, 24'sh000001, 24'sh000000, 1'b1);
    queue_fixed(24'sh000000, 24'sh000000, 24'sh000000, 1'b0);
    queue_fixed(24'sh001000, 24'sh001000, 24'sh001000, 1'b0);
    queue_fixed(24'sh002000, 24'sh002000, 24'sh002000, 1'b1);
    queue_fixed(24'sh000000, 24'sh000000, 24'sh000000, 1'b0);
    queue_fixed(24'sh001000, 24'sh000000, 24'sh000000, 1'b0);
    queue_fixed(24'sh000000, 24'sh001000, 24'sh000000, 1'b0);
    queue_fixed(24'shFFF000, 24'sh000000, 24'sh000000, 1'b1);
    queue_polygon(NVERT + 3, 2);
    // Random polygons across four idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 76 : 29) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 76 : 29) : 0;
      for (int p = 0; p < 7; p++) begin
        int r;
        r = $urandom_range(99);
        queue_polygon(r < 10 ? $urandom_range(1, 2) : (r < 95 ? $urandom_range(3, 8) :
                      $urandom_range(NVERT - 1, NVERT + 2)), $urandom_range(2));
      end
      // A phase ends once every word has been taken and every normal checked.
      wait (pending_words.size() == 0 && !in_valid && expected_normals.size() == 0);
    end
    feed_done = 1;
  end

  initial begin
    wait (feed_done);
    repeat (2000) @(posedge clk);
    $display("Sent %0d vertex words in %0d polygons, checked %0d normal words.",
             words_sent, polygons_done, normals_seen);
    if (mismatches == 0 && expected_normals.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #50ms;
    $display("Timed out with %0d normals outstanding.", expected_normals.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
